// ===== rtl/bdpc_pkg.sv =====
// Shared types and constants for the button debounce and press classifier.
// Used by bdpc_core and button_debounce_press_classifier_unit; no dependencies.
package bdpc_pkg;

	localparam int CMD_W     = 2;
	localparam int MODE_W    = 2;
	localparam int DEB_W     = 8;
	localparam int PRESS_W   = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 16;

	// Commands carried by an item.
	localparam logic [CMD_W-1:0] CMD_TICK      = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DONE      = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TAKE_START = 2'd2;
	localparam logic [CMD_W-1:0] CMD_TAKE_LONG = 2'd3;

	// Classifier modes.
	localparam logic [MODE_W-1:0] MODE_IDLE    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MEASURE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WAITREL = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNUSED  = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 1'd1;

	localparam logic [DEB_W-1:0]   DEBOUNCE_TICKS_RST   = 8'd30;
	localparam logic [PRESS_W-1:0] LONG_PRESS_TICKS_RST = 16'd3000;
	localparam logic [DEB_W-1:0]   DEB_MAX   = '1;
	localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             raw_level;
	} item_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic              debounced_level;
		logic              flag_value;
	} result_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

endpackage

// ===== rtl/bdpc_core.sv =====
// Debouncer, press timer, classifier state and configuration registers.
// Depends on bdpc_pkg; one item is applied per cycle in which step is high.
module bdpc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  bdpc_pkg::cfg_wr_t cfg,
	input  logic             step,
	input  bdpc_pkg::item_t  item,
	output bdpc_pkg::result_t result
);
	import bdpc_pkg::*;

	logic [DEB_W-1:0]   debounce_ticks_q;
	logic [PRESS_W-1:0] long_press_ticks_q;
	logic               previous_raw_q;
	logic               stable_q;
	logic [DEB_W-1:0]   since_q;
	logic [PRESS_W-1:0] press_q;
	logic               press_active_q;
	logic [MODE_W-1:0]  mode_q;
	logic               start_flag_q;
	logic               long_flag_q;

	logic               previous_raw_d;
	logic               stable_d;
	logic [DEB_W-1:0]   since_d;
	logic [PRESS_W-1:0] press_d;
	logic               press_active_d;
	logic [MODE_W-1:0]  mode_d;
	logic               start_flag_d;
	logic               long_flag_d;
	logic               flag;

	always_comb begin
		previous_raw_d = previous_raw_q;
		stable_d       = stable_q;
		since_d        = since_q;
		press_d        = press_q;
		press_active_d = press_active_q;
		mode_d         = mode_q;
		start_flag_d   = start_flag_q;
		long_flag_d    = long_flag_q;
		flag           = 1'b0;
		case (item.command)
			CMD_TICK: begin
				if (item.raw_level != previous_raw_q) begin
					previous_raw_d = item.raw_level;
					since_d        = '0;
				end else if (since_q != DEB_MAX) begin
					since_d = since_q + 1'b1;
				end
				if (since_d >= debounce_ticks_q) begin
					stable_d = item.raw_level;
				end
				if (mode_q == MODE_IDLE) begin
					if (!stable_d) begin
						if (!press_active_q) begin
							press_active_d = 1'b1;
							press_d        = '0;
						end else if (press_q != PRESS_MAX) begin
							press_d = press_q + 1'b1;
						end
						if (press_d >= long_press_ticks_q) begin
							press_active_d = 1'b0;
							long_flag_d    = 1'b1;
							mode_d         = MODE_MEASURE;
						end
					end else if (press_active_q) begin
						press_active_d = 1'b0;
						start_flag_d   = 1'b1;
						mode_d         = MODE_MEASURE;
					end
				end else if (mode_q == MODE_WAITREL) begin
					if (stable_d) begin
						mode_d = MODE_IDLE;
					end
				end
			end
			CMD_DONE: begin
				if (mode_q == MODE_MEASURE) begin
					mode_d = MODE_WAITREL;
				end
			end
			CMD_TAKE_START: begin
				flag         = start_flag_q;
				start_flag_d = 1'b0;
			end
			CMD_TAKE_LONG: begin
				flag        = long_flag_q;
				long_flag_d = 1'b0;
			end
			default: begin
				flag = 1'b0;
			end
		endcase
	end

	always_comb begin
		result.mode            = mode_d;
		result.debounced_level = stable_d;
		result.flag_value      = flag;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_raw_q <= 1'b1;
			stable_q       <= 1'b1;
			since_q        <= '0;
			press_q        <= '0;
			press_active_q <= 1'b0;
			mode_q         <= MODE_IDLE;
			start_flag_q   <= 1'b0;
			long_flag_q    <= 1'b0;
		end else if (step) begin
			previous_raw_q <= previous_raw_d;
			stable_q       <= stable_d;
			since_q        <= since_d;
			press_q        <= press_d;
			press_active_q <= press_active_d;
			mode_q         <= mode_d;
			start_flag_q   <= start_flag_d;
			long_flag_q    <= long_flag_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_ticks_q   <= DEBOUNCE_TICKS_RST;
			long_press_ticks_q <= LONG_PRESS_TICKS_RST;
		end else if (cfg.en) begin
			if (cfg.index == CFG_DEBOUNCE_TICKS) begin
				debounce_ticks_q <= cfg.data[DEB_W-1:0];
			end
			if (cfg.index == CFG_LONG_PRESS_TICKS) begin
				long_press_ticks_q <= cfg.data[PRESS_W-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	// A press is only timed while idle.
	a_press_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		press_active_q |-> mode_q == MODE_IDLE)
		else $error("press timer active outside idle");

	a_mode_reachable: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q != MODE_UNUSED)
		else $error("unused mode code reached");

	// Leaving idle always raises exactly one of the two flags.
	a_leave_idle_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(step && mode_q == MODE_IDLE && mode_d == MODE_MEASURE)
		|=> (start_flag_q || long_flag_q))
		else $error("left idle without a flag");

	a_hold_without_step: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(mode_q) && $stable(since_q) && $stable(press_q))
		else $error("state changed without an item");
`endif

endmodule

// ===== rtl/button_debounce_press_classifier_unit.sv =====
// Top level of the button debounce and press classifier.
// Depends on bdpc_pkg and bdpc_core.
//
//   channel  direction  handshake              payload
//   cmd      in         cmd_valid / cmd_stall  bdpc_pkg::item_t
//   res      out        res_valid / res_stall  bdpc_pkg::result_t
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item is applied to the state while it is in the input register and the
// result register can take it, and is registered into the result register;
// its result is offered from there and leaves once res_stall is low.
// One item per cycle is sustained unless res stalls (single state update path).
// Reset clears the state, loads the register defaults and empties both stages.
// A stall on res holds the result register and, through it, the input register.
module button_debounce_press_classifier_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cmd_valid,
	output logic                                 cmd_stall,
	input  bdpc_pkg::item_t                      cmd,
	output logic                                 res_valid,
	input  logic                                 res_stall,
	output bdpc_pkg::result_t                    res,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [bdpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bdpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import bdpc_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    res_valid_q;
	result_t res_q;
	result_t result;
	logic    advance;
	logic    step;
	cfg_wr_t cfg_wr;

	// The result register can take a new item when empty or being drained.
	assign advance   = !res_valid_q || !res_stall;
	assign step      = valid_s1 && advance;
	assign cmd_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		cfg_wr.en    = cfg_valid && cfg_ready;
		cfg_wr.index = cfg_index;
		cfg_wr.data  = cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!cmd_stall) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			item_s1 <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= result;
		end
	end

	bdpc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_wr),
		.step   (step),
		.item   (item_s1),
		.result (result)
	);

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with no item held");

	// An item held in the input register is not lost while stalled.
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(item_s1))
		else $error("stalled input item lost");

	a_res_mode_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> res_q.mode != MODE_UNUSED)
		else $error("result carries unused mode");
`endif

endmodule
